/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i once rst_ni is released.
`define DBQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dbq assertion failed");

// Checked at every rising edge of clk_i, also while rst_ni is low.
`define DBQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("dbq reset assertion failed");

`endif

/* rtl/core/dbq_pkg.sv */
`default_nettype none

package dbq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;
  localparam logic [2:0] CMD_LIST       = 3'd5;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_ITEM  = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REVERSE,
    OP_LIST
  } dbq_op_e;

  typedef struct packed {
    dbq_op_e            op;
    logic signed [31:0] value;
  } dbq_item_t;

endpackage

`default_nettype wire

/* rtl/core/dbq_front.sv */
`default_nettype none

module dbq_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [31:0] value_i,
  output logic                    push_valid_o,
  input  wire logic               push_stall_i,
  output dbq_pkg::dbq_item_t      push_item_o
);

  logic               valid_q, valid_d;
  dbq_pkg::dbq_item_t item_q, item_d;
  dbq_pkg::dbq_op_e   op;
  logic               accept;

  always_comb begin
    case (command_i)
      dbq_pkg::CMD_PUSH_FRONT: op = dbq_pkg::OP_PUSH_FRONT;
      dbq_pkg::CMD_PUSH_BACK:  op = dbq_pkg::OP_PUSH_BACK;
      dbq_pkg::CMD_POP_FRONT:  op = dbq_pkg::OP_POP_FRONT;
      dbq_pkg::CMD_POP_BACK:   op = dbq_pkg::OP_POP_BACK;
      dbq_pkg::CMD_REVERSE:    op = dbq_pkg::OP_REVERSE;
      dbq_pkg::CMD_LIST:       op = dbq_pkg::OP_LIST;
      default:                 op = dbq_pkg::OP_NOP;
    endcase
  end

  assign stall_o = valid_q & push_stall_i;
  assign accept  = valid_i & ~stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d      = 1'b1;
      item_d.op    = op;
      item_d.value = value_i;
    end else if (valid_q && !push_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/core/dbq_fifo.sv */
`default_nettype none

module dbq_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_stall_o,
  input  wire dbq_pkg::dbq_item_t push_item_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output dbq_pkg::dbq_item_t      pop_item_o
);

  dbq_pkg::dbq_item_t entry_q [2];
  logic               wr_q, wr_d;
  logic               rd_q, rd_d;
  logic [1:0]         count_q, count_d;
  logic               push, pop;

  assign push_stall_o = (count_q == 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = entry_q[rd_q];

  always_comb begin
    wr_d    = push ? ~wr_q : wr_q;
    rd_d    = pop ? ~rd_q : rd_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dbq_back.sv */
`default_nettype none

`include "assert_macros.svh"

module dbq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  input  wire dbq_pkg::dbq_item_t pop_item_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [31:0]      element_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW:0]   DepthX = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  function automatic logic [PtrW-1:0] phys_f(input logic [PtrW-1:0] base,
                                             input logic [PtrW-1:0] pos,
                                             input logic            rev);
    logic [PtrW:0] sum;
    if (rev) begin
      sum = {1'b0, base} + DepthX - {1'b0, pos};
    end else begin
      sum = {1'b0, base} + {1'b0, pos};
    end
    if (sum >= DepthX) begin
      sum = sum - DepthX;
    end
    return sum[PtrW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [PtrW-1:0]    front_q, front_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               rev_q, rev_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] elem_q, elem_d;
  logic [1:0]         status_q, status_d;
  logic               last_q, last_d;
  logic [31:0]        mem_q [DEPTH];
  logic [31:0]        rd_q;
  logic               we, re;
  logic [PtrW-1:0]    wa, ra;
  logic               out_free, pop, is_full, is_empty, list_last;
  logic [CntW-1:0]    count_less;

  assign out_free   = ~out_valid_q | ~stall_i;
  assign pop_ready_o = (state_q == ST_IDLE) & out_free;
  assign pop        = pop_valid_i & pop_ready_o;
  assign is_full    = (count_q == DepthC);
  assign is_empty   = (count_q == '0);
  assign count_less = count_q - CntW'(1);
  assign list_last  = ((idx_q + CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rev_d       = rev_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & stall_i;
    elem_d      = elem_q;
    status_d    = status_q;
    last_d      = last_q;
    we          = 1'b0;
    wa          = front_q;
    re          = 1'b0;
    ra          = phys_f(front_q, idx_q[PtrW-1:0], rev_q);
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          out_valid_d = 1'b1;
          elem_d      = '0;
          status_d    = dbq_pkg::STATUS_DONE;
          last_d      = 1'b1;
          case (pop_item_i.op)
            dbq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = dbq_pkg::STATUS_FULL;
              end else begin
                if (!is_empty) begin
                  front_d = phys_f(front_q, PtrW'(1), ~rev_q);
                end
                we      = 1'b1;
                wa      = front_d;
                count_d = count_q + CntW'(1);
              end
            end
            dbq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = dbq_pkg::STATUS_FULL;
              end else begin
                we      = 1'b1;
                wa      = phys_f(front_q, count_q[PtrW-1:0], rev_q);
                count_d = count_q + CntW'(1);
              end
            end
            dbq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                status_d = dbq_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_less;
                if (count_less != '0) begin
                  front_d = phys_f(front_q, PtrW'(1), rev_q);
                end
              end
            end
            dbq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                status_d = dbq_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_less;
              end
            end
            dbq_pkg::OP_REVERSE: begin
              if (!is_empty) begin
                front_d = phys_f(front_q, count_less[PtrW-1:0], rev_q);
              end
              rev_d = ~rev_q;
            end
            dbq_pkg::OP_LIST: begin
              if (is_empty) begin
                status_d = dbq_pkg::STATUS_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                idx_d       = '0;
                state_d     = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        re      = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          elem_d      = rd_q;
          status_d    = dbq_pkg::STATUS_ITEM;
          last_d      = list_last;
          if (list_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q   <= elem_d;
    status_q <= status_d;
    last_q   <= last_d;
    if (we) begin
      mem_q[wa] <= pop_item_i.value;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  assign valid_o   = out_valid_q;
  assign element_o = elem_q;
  assign status_o  = status_q;
  assign last_o    = last_q;

  `DBQ_ASSERT(a_count_bound, count_q <= DepthC)
  `DBQ_ASSERT(a_list_index, (state_q != ST_IDLE) |-> (idx_q < count_q))
  `DBQ_ASSERT(a_list_holds_state, (state_q != ST_IDLE) |=> $stable(count_q) && $stable(front_q))
  `DBQ_ASSERT(a_list_start,
              (pop && pop_item_i.op == dbq_pkg::OP_LIST && !is_empty) |=> (state_q == ST_READ))
  `DBQ_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE) && !out_valid_q)

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_with_reverse.sv */
// Bounded double-ended queue of up to DEPTH signed 32-bit elements with reversal.
// Input channel: valid_i, stall_o, command_i, value_i; one command per transfer.
// Output channel: valid_o, stall_i, element_o, status_o, last_o; last_o marks the
// final result of a command.
// Insert, remove, reverse and unused codes give one result. List gives one
// result per element from front to back, or a single empty status.
// A non-list result passes through the input register, the command queue and the
// output register; each list element also needs a registered read of the element
// memory before it is emitted.
// Throughput: one non-list command per cycle while the receiver does not stall; a
// list command alternates a registered element memory read with each emit.
// The input side keeps accepting into the command queue while a list runs or
// while a result waits, and stalls once the queue and input register are full.
// When the receiver stalls, the output register holds its result unchanged.
// Reset empties the store, clears the reverse flag and drops queued commands;
// element memory contents are not cleared.
`default_nettype none

module bounded_deque_with_reverse #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [31:0] value_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [31:0]      element_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  logic               push_valid, push_stall, pop_valid, pop_ready;
  dbq_pkg::dbq_item_t push_item, pop_item;

  dbq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_item_o  (push_item)
  );

  dbq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  dbq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .element_o   (element_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

/* dv/tb_bounded_deque_with_reverse.sv */
`timescale 1ns / 100ps

module tb_bounded_deque_with_reverse;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;
  localparam int END_SETTLE_CYCLES = 24;
  localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

  typedef struct packed {
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;
  } deque_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [2:0]         command_i = dbq_pkg::CMD_PUSH_FRONT;
  logic signed [31:0] value_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [31:0] element_o;
  logic [1:0]         status_o;
  logic               last_o;

  deque_result_t expected_results[$];

  logic signed [31:0] mirror_slots[DEPTH];
  int mirror_front = 0;
  int mirror_count = 0;
  logic mirror_reversed = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int commands_accepted = 0;
  int results_checked = 0;
  int lists_sent = 0;
  int full_refusals = 0;
  int peak_count = 0;

  bounded_deque_with_reverse #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .command_i(command_i),
    .value_i(value_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .element_o(element_o),
    .status_o(status_o),
    .last_o(last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int slot_of(int pos);
    if (mirror_reversed) begin
      return (mirror_front + DEPTH - (pos % DEPTH)) % DEPTH;
    end
    return (mirror_front + pos) % DEPTH;
  endfunction

  function automatic void add_expected(logic signed [31:0] element, logic [1:0] status,
                                       logic last);
    deque_result_t res;
    res.element = element;
    res.status = status;
    res.last = last;
    expected_results.push_back(res);
  endfunction

  function automatic void predict_command(logic [2:0] cmd, logic signed [31:0] val);
    case (cmd)
      dbq_pkg::CMD_PUSH_FRONT, dbq_pkg::CMD_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          full_refusals++;
          add_expected('0, dbq_pkg::STATUS_FULL, 1'b1);
        end else begin
          if (cmd == dbq_pkg::CMD_PUSH_FRONT) begin
            if (mirror_count != 0) begin
              mirror_front = mirror_reversed ? (mirror_front + 1) % DEPTH
                                             : (mirror_front + DEPTH - 1) % DEPTH;
            end
            mirror_slots[mirror_front] = val;
          end else begin
            mirror_slots[slot_of(mirror_count)] = val;
          end
          mirror_count++;
          if (mirror_count > peak_count) begin
            peak_count = mirror_count;
          end
          add_expected('0, dbq_pkg::STATUS_DONE, 1'b1);
        end
      end
      dbq_pkg::CMD_POP_FRONT, dbq_pkg::CMD_POP_BACK: begin
        if (mirror_count == 0) begin
          add_expected('0, dbq_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          mirror_count--;
          if (cmd == dbq_pkg::CMD_POP_FRONT && mirror_count != 0) begin
            mirror_front = mirror_reversed ? (mirror_front + DEPTH - 1) % DEPTH
                                           : (mirror_front + 1) % DEPTH;
          end
          add_expected('0, dbq_pkg::STATUS_DONE, 1'b1);
        end
      end
      dbq_pkg::CMD_REVERSE: begin
        if (mirror_count != 0) begin
          mirror_front = slot_of(mirror_count - 1);
        end
        mirror_reversed = ~mirror_reversed;
        add_expected('0, dbq_pkg::STATUS_DONE, 1'b1);
      end
      dbq_pkg::CMD_LIST: begin
        lists_sent++;
        if (mirror_count == 0) begin
          add_expected('0, dbq_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            add_expected(mirror_slots[slot_of(i)], dbq_pkg::STATUS_ITEM,
                         i == mirror_count - 1);
          end
        end
      end
      default: begin
        add_expected('0, dbq_pkg::STATUS_DONE, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && valid_o && !stall_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(status_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (element_o !== want.element) begin
          report_mismatch("element", element_o, want.element);
        end
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
    end
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL bounded_deque_with_reverse");
    $finish;
  end

  task automatic send_command(logic [2:0] cmd, logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    value_i <= val;
    do begin
      @(posedge clk_i);
    end while (stall_o);
    commands_accepted++;
    predict_command(cmd, val);
  endtask

  task automatic wait_results_drained();
    valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_results.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_store();
    send_command(dbq_pkg::CMD_POP_FRONT, 32'sh7fffffff);
    send_command(dbq_pkg::CMD_POP_BACK, 32'sh80000000);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_REVERSE, -32'sd1);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_REVERSE, '0);
    send_command(CMD_RESERVED_6, 32'sh12345678);
    send_command(CMD_RESERVED_7, -32'sd1);
    wait_results_drained();
  endtask

  task automatic test_basic_commands();
    send_command(dbq_pkg::CMD_PUSH_FRONT, 32'sh7fffffff);
    send_command(dbq_pkg::CMD_PUSH_BACK, 32'sh80000000);
    send_command(dbq_pkg::CMD_PUSH_FRONT, -32'sd1);
    send_command(dbq_pkg::CMD_PUSH_BACK, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_REVERSE, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_PUSH_FRONT, 32'sd5);
    send_command(dbq_pkg::CMD_PUSH_BACK, 32'sd6);
    send_command(dbq_pkg::CMD_POP_FRONT, '0);
    send_command(dbq_pkg::CMD_POP_BACK, '0);
    send_command(CMD_RESERVED_7, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_REVERSE, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    wait_results_drained();
  endtask

  task automatic test_fill_to_full();
    while (mirror_count < DEPTH) begin
      if ($urandom_range(9) == 0) begin
        send_command(dbq_pkg::CMD_REVERSE, $urandom());
      end else begin
        send_command($urandom_range(1) ? dbq_pkg::CMD_PUSH_FRONT : dbq_pkg::CMD_PUSH_BACK,
                     pick_value());
      end
    end
    send_command(dbq_pkg::CMD_PUSH_FRONT, 32'sh7fffffff);
    send_command(dbq_pkg::CMD_PUSH_BACK, 32'sh80000000);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_REVERSE, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    send_command(dbq_pkg::CMD_POP_FRONT, '0);
    send_command(dbq_pkg::CMD_PUSH_BACK, pick_value());
    send_command(dbq_pkg::CMD_PUSH_FRONT, pick_value());
    send_command(dbq_pkg::CMD_LIST, '0);
    wait_results_drained();
  endtask

  task automatic test_hold_until_drained();
    send_command(dbq_pkg::CMD_PUSH_BACK, pick_value());
    send_command(dbq_pkg::CMD_LIST, '0);
    wait_results_drained();
    send_command(dbq_pkg::CMD_REVERSE, '0);
    send_command(dbq_pkg::CMD_LIST, '0);
    wait_results_drained();
  endtask

  task automatic test_random_mix(int n_items, int push_pct);
    int roll;
    logic [2:0] cmd;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        cmd = $urandom_range(1) ? dbq_pkg::CMD_PUSH_FRONT : dbq_pkg::CMD_PUSH_BACK;
      end else if (roll < push_pct + 10) begin
        cmd = dbq_pkg::CMD_LIST;
      end else if (roll < push_pct + 20) begin
        cmd = dbq_pkg::CMD_REVERSE;
      end else if (roll < push_pct + 23) begin
        cmd = $urandom_range(1) ? CMD_RESERVED_6 : CMD_RESERVED_7;
      end else begin
        cmd = $urandom_range(1) ? dbq_pkg::CMD_POP_FRONT : dbq_pkg::CMD_POP_BACK;
      end
      send_command(cmd, pick_value());
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 23;
    recv_stall_pct = 54;
    test_empty_store();
    test_basic_commands();
    test_random_mix(8, 55);

    send_idle_pct = 54;
    recv_stall_pct = 23;
    test_fill_to_full();
    test_hold_until_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(14, 35);

    wait_results_drained();
    repeat (END_SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands (%0d lists, %0d refused inserts), peak occupancy %0d of %0d.",
             commands_accepted, lists_sent, full_refusals, peak_count, DEPTH);
    $display("Checked %0d results with %0d field mismatches under three idle patterns.",
             results_checked, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS bounded_deque_with_reverse");
    end else begin
      $display("FAIL bounded_deque_with_reverse");
    end
    $finish;
  end

endmodule
